[rtl/lrfr_pkg.sv]
// Shared types, constants and helpers for the link response frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package lrfr_pkg;

	localparam int MAX_FRAME   = 256;
	localparam int FRAME_CNT_W = $clog2(MAX_FRAME + 1);
	localparam int ECHO_LEN    = 4;
	localparam int APB_AW      = 5;
	localparam int BURST_LAST  = 5;

	// line characters
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;

	// input opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_ARM  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_REPLY   = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SUM_BAD  = 3'd1;
	localparam logic [2:0] ST_NAK      = 3'd2;
	localparam logic [2:0] ST_BAD_HEAD = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	// register indexes
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_STATION = 3'd1;
	localparam logic [2:0] REG_PC      = 3'd2;
	localparam logic [2:0] REG_ACK_LEN = 3'd3;
	localparam logic [2:0] REG_NAK_LEN = 3'd4;
	localparam logic [2:0] REG_TIMEOUT = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FIRST,
		PH_FRAME,
		PH_SUM1,
		PH_SUM2,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic        response_mode;
		logic [15:0] station_code;
		logic [15:0] pc_code;
		logic [3:0]  ack_tail_len;
		logic [3:0]  nak_tail_len;
		logic [7:0]  timeout_ticks;
	} cfg_t;

	// one result descriptor: a single word, or the six-word reply burst
	typedef struct packed {
		logic       valid;
		logic       burst;
		logic       ok;
		logic [1:0] kind;
		logic [7:0] value;
		logic [2:0] status;
	} res_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return 8'h30 + {4'h0, nib};
		else
			return 8'h37 + {4'h0, nib};
	endfunction

endpackage

`default_nettype wire

[rtl/lrfr_regs.sv]
// APB register file for the receiver configuration.
// Depends on lrfr_pkg (cfg_t, APB_AW, register indexes); reset values are local.
`default_nettype none

module lrfr_regs import lrfr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.response_mode <= 1'b0;
			cfg_q.station_code  <= 16'h3030;
			cfg_q.pc_code       <= 16'h3030;
			cfg_q.ack_tail_len  <= 4'd4;
			cfg_q.nak_tail_len  <= 4'd6;
			cfg_q.timeout_ticks <= 8'd40;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:    cfg_q.response_mode <= pwdata[0];
				REG_STATION: cfg_q.station_code  <= pwdata[15:0];
				REG_PC:      cfg_q.pc_code       <= pwdata[15:0];
				REG_ACK_LEN: cfg_q.ack_tail_len  <= pwdata[3:0];
				REG_NAK_LEN: cfg_q.nak_tail_len  <= pwdata[3:0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:    prdata = {31'h0, cfg_q.response_mode};
			REG_STATION: prdata = {16'h0, cfg_q.station_code};
			REG_PC:      prdata = {16'h0, cfg_q.pc_code};
			REG_ACK_LEN: prdata = {28'h0, cfg_q.ack_tail_len};
			REG_NAK_LEN: prdata = {28'h0, cfg_q.nak_tail_len};
			REG_TIMEOUT: prdata = {24'h0, cfg_q.timeout_ticks};
			default:     prdata = 32'h0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/lrfr_parse.sv]
// Response parser: phase state machine, checksum, frame count and idle timer.
// Depends on lrfr_pkg (phase_t, cfg_t, res_t, codes, hex_char).
`default_nettype none

module lrfr_parse import lrfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] line_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	phase_t                 phase_q, phase_d;
	logic [FRAME_CNT_W-1:0] frame_count_q, frame_count_d;
	logic [7:0]             running_sum_q, running_sum_d;
	logic [7:0]             first_sum_char_q, first_sum_char_d;
	logic [3:0]             tail_left_q, tail_left_d;
	logic                   nak_seen_q, nak_seen_d;
	logic [7:0]             idle_count_q, idle_count_d;

	logic [FRAME_CNT_W-1:0] fc_inc;
	logic                   fc_over;
	logic [3:0]             tail_dec;
	logic                   timed_out;
	logic                   sum_ok;
	logic                   active;

	assign fc_inc    = frame_count_q + 1'b1;
	assign fc_over   = fc_inc >= FRAME_CNT_W'(MAX_FRAME);
	assign tail_dec  = (tail_left_q != 4'd0) ? tail_left_q - 4'd1 : 4'd0;
	assign timed_out = idle_count_q >= cfg.timeout_ticks;
	assign sum_ok    = (first_sum_char_q == hex_char(running_sum_q[7:4]))
		&& (line_byte == hex_char(running_sum_q[3:0]));
	assign active    = phase_q != PH_IDLE;

	// next state
	always_comb begin
		phase_d          = phase_q;
		frame_count_d    = frame_count_q;
		running_sum_d    = running_sum_q;
		first_sum_char_d = first_sum_char_q;
		tail_left_d      = tail_left_q;
		nak_seen_d       = nak_seen_q;
		idle_count_d     = idle_count_q;
		if (opcode == OP_ARM) begin
			phase_d          = PH_FIRST;
			frame_count_d    = '0;
			running_sum_d    = '0;
			first_sum_char_d = '0;
			tail_left_d      = '0;
			nak_seen_d       = 1'b0;
			idle_count_d     = '0;
		end else if (opcode == OP_TICK && active) begin
			if (timed_out)
				phase_d = PH_IDLE;
			else
				idle_count_d = idle_count_q + 8'd1;
		end else if (opcode == OP_BYTE && active) begin
			idle_count_d = '0;
			case (phase_q)
				PH_FIRST: begin
					if (line_byte == CH_NAK) begin
						nak_seen_d  = 1'b1;
						tail_left_d = cfg.nak_tail_len;
						phase_d     = (cfg.nak_tail_len == 4'd0) ? PH_IDLE : PH_TAIL;
					end else if (!cfg.response_mode && line_byte == CH_STX) begin
						phase_d       = PH_FRAME;
						frame_count_d = '0;
						running_sum_d = '0;
					end else if (cfg.response_mode && line_byte == CH_ACK) begin
						nak_seen_d  = 1'b0;
						tail_left_d = cfg.ack_tail_len;
						phase_d     = (cfg.ack_tail_len == 4'd0) ? PH_IDLE : PH_TAIL;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_FRAME: begin
					frame_count_d = fc_inc;
					if (fc_over) begin
						phase_d = PH_IDLE;
					end else begin
						running_sum_d = running_sum_q + line_byte;
						if (line_byte == CH_ETX)
							phase_d = PH_SUM1;
					end
				end
				PH_SUM1: begin
					first_sum_char_d = line_byte;
					phase_d          = PH_SUM2;
				end
				PH_TAIL: begin
					tail_left_d = tail_dec;
					if (tail_dec == 4'd0)
						phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result descriptor
	always_comb begin
		res        = '0;
		res.kind   = KIND_STATUS;
		if (opcode == OP_TICK && active) begin
			if (timed_out) begin
				res.valid  = 1'b1;
				res.status = ST_TIMEOUT;
			end
		end else if (opcode == OP_BYTE && active) begin
			case (phase_q)
				PH_FIRST: begin
					if (line_byte == CH_NAK) begin
						res.valid  = cfg.nak_tail_len == 4'd0;
						res.status = ST_NAK;
					end else if (!cfg.response_mode && line_byte == CH_STX) begin
						res.valid = 1'b0;
					end else if (cfg.response_mode && line_byte == CH_ACK) begin
						res.valid  = cfg.ack_tail_len == 4'd0;
						res.status = ST_OK;
					end else begin
						res.valid  = 1'b1;
						res.status = ST_BAD_HEAD;
					end
				end
				PH_FRAME: begin
					if (fc_over) begin
						res.valid  = 1'b1;
						res.status = ST_OVERFLOW;
					end else if (line_byte != CH_ETX
						&& fc_inc > FRAME_CNT_W'(ECHO_LEN)) begin
						res.valid = 1'b1;
						res.kind  = KIND_PAYLOAD;
						res.value = line_byte;
					end
				end
				PH_SUM2: begin
					res.valid = 1'b1;
					res.burst = 1'b1;
					res.ok    = sum_ok;
				end
				PH_TAIL: begin
					res.valid  = tail_dec == 4'd0;
					res.status = nak_seen_q ? ST_NAK : ST_OK;
				end
				default: res.valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			frame_count_q    <= '0;
			running_sum_q    <= '0;
			first_sum_char_q <= '0;
			tail_left_q      <= '0;
			nak_seen_q       <= 1'b0;
			idle_count_q     <= '0;
		end else if (go) begin
			phase_q          <= phase_d;
			frame_count_q    <= frame_count_d;
			running_sum_q    <= running_sum_d;
			first_sum_char_q <= first_sum_char_d;
			tail_left_q      <= tail_left_d;
			nak_seen_q       <= nak_seen_d;
			idle_count_q     <= idle_count_d;
		end
	end

endmodule

`default_nettype wire

[rtl/link_response_frame_receiver.sv]
// Link response frame receiver: master-side parser for an ASCII serial PLC link.
// Channels: input words (opcode, line_byte) on in_valid/in_ready; result words
// (kind, value, status, last) on out_valid/out_ready; configuration over APB.
// An arm word starts a wait for a response; line bytes and ticks then drive the
// parser. Data frames stream payload words, then a five-word ACK/NAK reply
// and a status word; ack responses, errors and timeouts end in one status word.
// Payload must be dropped by the consumer when the closing status is not ok.
// An accepted word is held in the input register, then parsed as its result is
// loaded into the result register, once that register is empty or giving its final word.
// Throughput: one input word per cycle while the result register is empty or
// giving its final word. The input register can take one new word while a result
// waits on a stalled output; the output stage holds one result descriptor, so a
// checksum word occupies it for six output words and any other result for one. A
// stalled receiver backs up into in_ready after one more input word.
// Reset: configuration returns to its defaults, the parser goes idle and both
// register stages are emptied. No clearing pass is needed.
// Depends on lrfr_pkg, lrfr_regs and lrfr_parse.
`default_nettype none

module link_response_frame_receiver import lrfr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        opcode,
	input  wire logic [7:0]        line_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [1:0]        kind,
	output logic      [7:0]        value,
	output logic      [2:0]        status,
	output logic                   last,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	cfg_t       cfg;
	res_t       res;
	res_t       desc_q;
	logic [2:0] beat_q;
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [7:0] byte_s1;
	logic       final_beat;
	logic       out_done;
	logic       advance;

	lrfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lrfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.opcode    (opcode_s1),
		.line_byte (byte_s1),
		.cfg       (cfg),
		.res       (res)
	);

	assign final_beat = !desc_q.burst || beat_q == 3'(BURST_LAST);
	assign out_done   = desc_q.valid && out_ready && final_beat;
	assign advance    = valid_s1 && (!desc_q.valid || out_done);
	assign in_ready   = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1 <= opcode;
			byte_s1   <= line_byte;
		end
	end

	// result register; advance through the reply burst one word at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= '0;
			beat_q <= '0;
		end else if (advance && res.valid) begin
			desc_q <= res;
			beat_q <= '0;
		end else if (out_done) begin
			desc_q.valid <= 1'b0;
			beat_q       <= '0;
		end else if (desc_q.valid && out_ready) begin
			beat_q <= beat_q + 3'd1;
		end
	end

	assign out_valid = desc_q.valid;

	always_comb begin
		kind   = KIND_REPLY;
		value  = 8'h00;
		status = ST_OK;
		last   = 1'b0;
		if (desc_q.burst) begin
			case (beat_q)
				3'd0:    value = desc_q.ok ? CH_ACK : CH_NAK;
				3'd1:    value = cfg.station_code[15:8];
				3'd2:    value = cfg.station_code[7:0];
				3'd3:    value = cfg.pc_code[15:8];
				3'd4:    value = cfg.pc_code[7:0];
				default: begin
					kind   = KIND_STATUS;
					status = desc_q.ok ? ST_OK : ST_SUM_BAD;
					last   = 1'b1;
				end
			endcase
		end else begin
			kind   = desc_q.kind;
			value  = desc_q.value;
			status = desc_q.status;
			last   = desc_q.kind == KIND_STATUS;
		end
	end

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		desc_q.valid && desc_q.burst |-> beat_q <= 3'(BURST_LAST))
		else $error("reply burst counter out of range");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		desc_q.valid && !desc_q.burst |-> beat_q == 3'd0)
		else $error("single result with nonzero burst counter");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_STATUS && value == 8'h00)
		else $error("last word is not a clean status word");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_done && !advance |=> !out_valid)
		else $error("result register not emptied after final word");

	a_parse_feeds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> out_valid && beat_q == 3'd0)
		else $error("parsed result not loaded");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for link_response_frame_receiver: drives arm words, line bytes and ticks,
// predicts every payload, reply and status word and checks them field by field.
// Depends on lrfr_pkg and the block's RTL only.

module tb_top;
	import lrfr_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_WORDS  = 120;
	localparam int CONFIG_SETS   = 6;

	// checksum character faults
	localparam int CK_GOOD   = 0;
	localparam int CK_LOWER  = 1;
	localparam int CK_RANDOM = 2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [2:0] status;
		logic       last;
	} out_word_t;

	class reply_scoreboard;
		localparam int REPORT_MAX = 10;

		cfg_t        cfg;
		phase_t      stage;
		int unsigned frame_len;
		logic [7:0]  sum_acc;
		logic [7:0]  sum_hi_char;
		logic [3:0]  tail_cnt;
		bit          nak_run;
		logic [7:0]  quiet_ticks;
		out_word_t   due_words[$];
		int unsigned errs;

		function new();
			cfg = '{response_mode: 1'b0, station_code: 16'h3030, pc_code: 16'h3030,
				ack_tail_len: 4'd4, nak_tail_len: 4'd6, timeout_ticks: 8'd40};
			stage = PH_IDLE;
			frame_len = 0;
			sum_acc = '0;
			sum_hi_char = '0;
			tail_cnt = '0;
			nak_run = 1'b0;
			quiet_ticks = '0;
			errs = 0;
		endfunction

		static function logic [7:0] hex_upper(input logic [3:0] nib);
			string digits;
			digits = "0123456789ABCDEF";
			return digits[nib];
		endfunction

		function void set_reg(input logic [2:0] idx, input logic [31:0] d);
			case (idx)
				REG_MODE:    cfg.response_mode = d[0];
				REG_STATION: cfg.station_code = d[15:0];
				REG_PC:      cfg.pc_code = d[15:0];
				REG_ACK_LEN: cfg.ack_tail_len = d[3:0];
				REG_NAK_LEN: cfg.nak_tail_len = d[3:0];
				REG_TIMEOUT: cfg.timeout_ticks = d[7:0];
				default: ;
			endcase
		endfunction

		function void push_word(input logic [1:0] k, input logic [7:0] v,
				input logic [2:0] s, input logic l);
			due_words.push_back({k, v, s, l});
		endfunction

		function void end_run(input logic [2:0] s);
			stage = PH_IDLE;
			push_word(KIND_STATUS, 8'h00, s, 1'b1);
		endfunction

		function void open_tail(input bit got_nak);
			nak_run = got_nak;
			tail_cnt = got_nak ? cfg.nak_tail_len : cfg.ack_tail_len;
			if (tail_cnt == 0)
				end_run(got_nak ? ST_NAK : ST_OK);
			else
				stage = PH_TAIL;
		endfunction

		// Advance the parser by one accepted word; return 0 if the block ignores it.
		function bit note_word(input logic [1:0] op, input logic [7:0] b);
			bit sum_ok;
			if (op == OP_ARM) begin
				stage = PH_FIRST;
				frame_len = 0;
				sum_acc = '0;
				sum_hi_char = '0;
				tail_cnt = '0;
				nak_run = 1'b0;
				quiet_ticks = '0;
				return 1'b1;
			end
			if (op == OP_UNUSED || stage == PH_IDLE)
				return 1'b0;
			if (op == OP_TICK) begin
				if (quiet_ticks >= cfg.timeout_ticks)
					end_run(ST_TIMEOUT);
				else
					quiet_ticks++;
				return 1'b1;
			end
			quiet_ticks = '0;
			case (stage)
				PH_FIRST: begin
					if (b == CH_NAK)
						open_tail(1'b1);
					else if (!cfg.response_mode && b == CH_STX) begin
						stage = PH_FRAME;
						frame_len = 0;
						sum_acc = '0;
					end else if (cfg.response_mode && b == CH_ACK)
						open_tail(1'b0);
					else
						end_run(ST_BAD_HEAD);
				end
				PH_FRAME: begin
					frame_len++;
					if (frame_len >= MAX_FRAME)
						end_run(ST_OVERFLOW);
					else begin
						sum_acc += b;
						if (b == CH_ETX)
							stage = PH_SUM1;
						else if (frame_len > ECHO_LEN)
							push_word(KIND_PAYLOAD, b, '0, 1'b0);
					end
				end
				PH_SUM1: begin
					sum_hi_char = b;
					stage = PH_SUM2;
				end
				PH_SUM2: begin
					sum_ok = sum_hi_char == hex_upper(sum_acc[7:4]) &&
						b == hex_upper(sum_acc[3:0]);
					push_word(KIND_REPLY, sum_ok ? CH_ACK : CH_NAK, '0, 1'b0);
					push_word(KIND_REPLY, cfg.station_code[15:8], '0, 1'b0);
					push_word(KIND_REPLY, cfg.station_code[7:0], '0, 1'b0);
					push_word(KIND_REPLY, cfg.pc_code[15:8], '0, 1'b0);
					push_word(KIND_REPLY, cfg.pc_code[7:0], '0, 1'b0);
					end_run(sum_ok ? ST_OK : ST_SUM_BAD);
				end
				PH_TAIL: begin
					if (tail_cnt > 0)
						tail_cnt--;
					if (tail_cnt == 0)
						end_run(nak_run ? ST_NAK : ST_OK);
				end
				default: stage = PH_IDLE;
			endcase
			return 1'b1;
		endfunction

		function void report(input string what, input out_word_t want, input out_word_t got);
			errs++;
			if (errs <= REPORT_MAX)
				$display("%s: expected kind %0d value 0x%02h status %0d last %0d, %s",
					what, want.kind, want.value, want.status, want.last,
					$sformatf("got kind %0d value 0x%02h status %0d last %0d",
						got.kind, got.value, got.status, got.last));
		endfunction

		function void check_word(input out_word_t got);
			out_word_t want;
			if (due_words.size() == 0) begin
				report("unexpected word", '0, got);
				return;
			end
			want = due_words.pop_front();
			if (got.kind !== want.kind || got.value !== want.value ||
					got.status !== want.status || got.last !== want.last)
				report("mismatch", want, got);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       opcode = OP_BYTE;
	logic [7:0]       line_byte = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       kind;
	logic [7:0]       value;
	logic [2:0]       status;
	logic             last;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	int unsigned send_idle_pct = 15;
	int unsigned recv_idle_pct = 64;
	int unsigned live_words = 0;
	int unsigned stall_cycles = 0;
	reply_scoreboard sb = new();

	link_response_frame_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .line_byte(line_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .status(status), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word({kind, value, status, last});
	end

	// end the run if neither channel moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else if (stall_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	task automatic send_word(input logic [1:0] op, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		line_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (sb.note_word(op, b))
			live_words++;
	endtask

	task automatic maybe_tick();
		if ($urandom_range(9) == 0)
			send_word(OP_TICK, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_ETX);
		return b;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_regs(input logic mode, input logic [15:0] station,
			input logic [15:0] pc, input logic [3:0] ack_len, input logic [3:0] nak_len,
			input logic [7:0] ticks);
		write_reg(REG_MODE, {31'd0, mode});
		write_reg(REG_STATION, {16'd0, station});
		write_reg(REG_PC, {16'd0, pc});
		write_reg(REG_ACK_LEN, {28'd0, ack_len});
		write_reg(REG_NAK_LEN, {28'd0, nak_len});
		write_reg(REG_TIMEOUT, {24'd0, ticks});
	endtask

	// drop valid, wait for every due word, then let a word with no result finish
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic send_frame(input int body_len, input int fault);
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] hi;
		logic [7:0] lo;
		sum = CH_ETX;
		send_word(OP_BYTE, CH_STX);
		for (int i = 0; i < body_len; i++) begin
			maybe_tick();
			b = body_byte();
			sum += b;
			send_word(OP_BYTE, b);
		end
		send_word(OP_BYTE, CH_ETX);
		hi = reply_scoreboard::hex_upper(sum[7:4]);
		lo = reply_scoreboard::hex_upper(sum[3:0]);
		if (fault == CK_LOWER) begin
			if (hi >= "A")
				hi = hi + 8'h20;
			else if (lo >= "A")
				lo = lo + 8'h20;
			else
				lo = lo ^ 8'h01;
		end else if (fault == CK_RANDOM)
			lo = 8'($urandom_range(255));
		send_word(OP_BYTE, hi);
		maybe_tick();
		send_word(OP_BYTE, lo);
	endtask

	task automatic send_ack_lead(input bit with_nak, input int short_by);
		int tail_len;
		send_word(OP_BYTE, with_nak ? CH_NAK : CH_ACK);
		tail_len = int'(with_nak ? sb.cfg.nak_tail_len : sb.cfg.ack_tail_len);
		for (int i = 0; i < tail_len - short_by; i++) begin
			maybe_tick();
			send_word(OP_BYTE, 8'($urandom_range(255)));
		end
	endtask

	task automatic run_sequence();
		int pick;
		int n;
		int fault;
		logic [7:0] b;
		pick = $urandom_range(99);
		fault = ($urandom_range(9) < 7) ? CK_GOOD : ($urandom_range(1) ? CK_LOWER : CK_RANDOM);
		send_word(OP_ARM, 8'($urandom_range(255)));
		maybe_tick();
		if (pick < 60) begin
			if (!sb.cfg.response_mode && $urandom_range(5) != 0)
				send_frame(($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10),
					fault);
			else
				send_ack_lead(sb.cfg.response_mode ? 1'($urandom_range(1)) : 1'b1, 0);
		end else if (pick < 70) begin
			do
				b = 8'($urandom_range(255));
			while (b == CH_NAK || b == CH_STX || b == CH_ACK);
			send_word(OP_BYTE, b);
		end else if (pick < 78) begin
			// go quiet until the tick budget runs out (only six ticks when it is above 40)
			if (!sb.cfg.response_mode) begin
				send_word(OP_BYTE, CH_STX);
				repeat ($urandom_range(3))
					send_word(OP_BYTE, body_byte());
			end
			n = (sb.cfg.timeout_ticks <= 40) ? sb.cfg.timeout_ticks + 1 : 6;
			repeat (n)
				send_word(OP_TICK, 8'($urandom_range(255)));
		end else if (pick < 86) begin
			// stop part way; the next arm abandons the run
			if (!sb.cfg.response_mode) begin
				send_word(OP_BYTE, CH_STX);
				repeat ($urandom_range(8))
					send_word(OP_BYTE, body_byte());
			end else
				send_ack_lead(1'($urandom_range(1)), 1);
		end else if (pick < 94) begin
			repeat ($urandom_range(6, 1))
				send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
		end else begin
			if (!sb.cfg.response_mode)
				send_frame($urandom_range(6), fault);
			else
				send_ack_lead(1'($urandom_range(1)), 0);
			repeat ($urandom_range(4, 1))
				send_word(2'($urandom_range(1)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [7:0] pattern[$];
		int unsigned base;
		int unsigned done_words;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ignored while idle
		send_word(OP_UNUSED, 8'hFF);
		send_word(OP_BYTE, CH_STX);
		send_word(OP_TICK, 8'h00);
		// bad first byte
		send_word(OP_ARM, 8'hFF);
		send_word(OP_BYTE, 8'hFF);
		// good frame: echo 00 FF 00 FF, payload FF 00, sum wraps to 00
		pattern = '{CH_STX, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, CH_ETX, "0", "0"};
		send_word(OP_ARM, 8'h00);
		foreach (pattern[i])
			send_word(OP_BYTE, pattern[i]);
		// re-arm mid frame, then an empty frame with a wrong checksum
		pattern = '{CH_STX, CH_ETX, "0", "4"};
		send_word(OP_ARM, 8'h00);
		send_word(OP_BYTE, CH_STX);
		foreach (pattern[i]) begin
			if (i == 0)
				send_word(OP_ARM, 8'h00);
			send_word(OP_BYTE, pattern[i]);
		end

		// overflow: the 256th byte after STX is ETX and must not be handled
		send_word(OP_ARM, 8'h00);
		send_word(OP_BYTE, CH_STX);
		for (int i = 1; i < MAX_FRAME; i++)
			send_word(OP_BYTE, body_byte());
		send_word(OP_BYTE, CH_ETX);

		base = live_words;
		for (int s = 0; s < CONFIG_SETS; s++) begin
			drain();
			case (s)
				0: load_regs(1'b0, 16'h3031, 16'h4646, 4'd4, 4'd6, 8'd40);
				1: load_regs(1'b1, 16'h0000, 16'hFFFF, 4'd0, 4'd15, 8'd1);
				2: load_regs(1'b0, 16'hFFFF, 16'h0000, 4'd15, 4'd0, 8'd255);
				3: load_regs(1'b1, 16'($urandom_range(16'hFFFF)),
					16'($urandom_range(16'hFFFF)), 4'd15, 4'd0, 8'd3);
				4: load_regs(1'b0, 16'($urandom_range(16'hFFFF)),
					16'($urandom_range(16'hFFFF)), 4'($urandom_range(15)),
					4'($urandom_range(15)), 8'($urandom_range(8, 1)));
				default: load_regs(1'b1, 16'($urandom_range(16'hFFFF)),
					16'($urandom_range(16'hFFFF)), 4'($urandom_range(15)),
					4'($urandom_range(15)), 8'd2);
			endcase
			while (live_words < base + RANDOM_WORDS * (s + 1) / CONFIG_SETS) begin
				done_words = live_words - base;
				if (done_words < RANDOM_WORDS / 3) begin
					send_idle_pct = 15;
					recv_idle_pct = 64;
				end else if (done_words < 2 * RANDOM_WORDS / 3) begin
					send_idle_pct = 64;
					recv_idle_pct = 15;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				run_sequence();
			end
		end
		drain();

		sb.errs += sb.due_words.size();
		if (sb.errs == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/lrfr_pkg.sv
rtl/lrfr_regs.sv
rtl/lrfr_parse.sv
rtl/link_response_frame_receiver.sv
tb/sv/tb_top.sv
